### rtl/core/wavhp_pkg.sv
// shared types and constants of the wav header parser
package wavhp_pkg;

  // chunk tags as little-endian 32-bit words
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  // offsets of the last byte of each fixed header field
  localparam logic [31:0] OFS_RIFF     = 32'd3;
  localparam logic [31:0] OFS_WAVE     = 32'd11;
  localparam logic [31:0] OFS_FMT      = 32'd15;
  localparam logic [31:0] OFS_FORMAT   = 32'd21;
  localparam logic [31:0] OFS_CHANNELS = 32'd23;
  localparam logic [31:0] OFS_RATE     = 32'd27;
  localparam logic [31:0] OFS_BYTERATE = 32'd31;
  localparam logic [31:0] OFS_ALIGN    = 32'd33;
  localparam logic [31:0] OFS_BITS     = 32'd35;

  localparam logic [31:0] FIRST_CHUNK_POS = 32'd36;
  localparam logic [31:0] CHUNK_HDR_LEN   = 32'd8;
  localparam logic [32:0] MAX_NEXT_HDR    = 33'h0_FFFF_FFF8;
  localparam logic [31:0] REL_ID_END      = 32'd3;
  localparam logic [31:0] REL_SIZE_END    = 32'd7;

  localparam logic [15:0] PCM_FORMAT = 16'd1;
  localparam logic [15:0] PCM_BITS   = 16'd16;
  localparam logic [15:0] MONO       = 16'd1;
  localparam logic [15:0] STEREO     = 16'd2;

  localparam logic STATUS_PASS = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // parser phase codes
  localparam logic [2:0] PH_WAIT   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_ID     = 3'd2;
  localparam logic [2:0] PH_DSIZE  = 3'd3;
  localparam logic [2:0] PH_OSIZE  = 3'd4;
  localparam logic [2:0] PH_SKIP   = 3'd5;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       first_byte;
    logic       last_byte;
  } wavhp_item_t;

  typedef struct packed {
    logic        status;
    logic [31:0] data_offset;
    logic [1:0]  channels;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
  } wavhp_res_t;

endpackage

### rtl/core/wavhp_if.sv
// channel interfaces for input bytes and parse results
interface wavhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, byte_value, first_byte, last_byte, input ready);
  modport sink (input valid, byte_value, first_byte, last_byte, output ready);
endinterface

interface wavhp_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [31:0] data_offset;
  logic [1:0]  channels;
  logic [31:0] sample_rate;
  logic [31:0] byte_rate;
  logic [15:0] block_align;

  modport source (output valid, status, data_offset, channels, sample_rate, byte_rate,
                  block_align, input ready);
  modport sink (input valid, status, data_offset, channels, sample_rate, byte_rate,
                block_align, output ready);
endinterface

### rtl/core/wavhp_queue.sv
// front queue that accepts input bytes and buffers them for the parser
module wavhp_queue
  import wavhp_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  wavhp_item_t push_item,
  output logic        full,
  input  logic        pop,
  output logic        q_valid,
  output wavhp_item_t q_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  wavhp_item_t         mem_r [DEPTH];
  logic [PW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### rtl/core/wavhp_parse.sv
// back end: per-byte header parser and result register
module wavhp_parse
  import wavhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  wavhp_item_t q_item,
  output logic        pop,
  output logic        res_valid,
  input  logic        res_ready,
  output wavhp_res_t  res
);

  logic [31:0] pos_r, pos_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [31:0] next_r, next_nxt;
  logic [31:0] next8_r, next8_nxt;
  logic [1:0]  chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [31:0] brate_r, brate_nxt;
  logic [15:0] align_r, align_nxt;
  logic        out_valid_r, out_valid_nxt;
  wavhp_res_t  out_r, out_nxt;

  logic        emit, emit_ok;
  logic [2:0]  ph;
  logic [31:0] p;
  logic [31:0] sh;
  logic [15:0] hi16;
  logic [31:0] rel;
  logic [32:0] nh;
  logic [31:0] nh8;

  // take the next byte when the result register can hold a new transaction
  assign pop       = q_valid && (!out_valid_r || res_ready);
  assign res_valid = out_valid_r;
  assign res       = out_r;

  // one parser step per byte
  always_comb begin
    pos_nxt   = pos_r;
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    next_nxt  = next_r;
    next8_nxt = next8_r;
    chan_nxt  = chan_r;
    rate_nxt  = rate_r;
    brate_nxt = brate_r;
    align_nxt = align_r;
    emit      = 1'b0;
    emit_ok   = 1'b0;
    ph        = q_item.first_byte ? PH_HEADER : phase_r;
    p         = q_item.first_byte ? '0 : pos_r;
    sh        = {q_item.byte_value, shift_r[31:8]};
    hi16      = sh[31:16];
    rel       = p - next_r;
    nh        = {1'b0, next_r} + {1'b0, CHUNK_HDR_LEN} + {1'b0, sh};
    nh8       = next8_r + sh + CHUNK_HDR_LEN;

    if (pop && ph != PH_WAIT) begin
      pos_nxt   = p + 32'd1;
      shift_nxt = sh;
      if (ph == PH_SKIP && p == next_r) begin
        ph = PH_ID;
      end
      phase_nxt = ph;
      if (ph == PH_HEADER) begin
        // fixed-offset header fields
        case (p)
          OFS_RIFF:     emit = (sh != TAG_RIFF);
          OFS_WAVE:     emit = (sh != TAG_WAVE);
          OFS_FMT:      emit = (sh != TAG_FMT);
          OFS_FORMAT:   emit = (hi16 != PCM_FORMAT);
          OFS_CHANNELS: begin
            emit     = !(hi16 inside {MONO, STEREO});
            chan_nxt = hi16[1:0];
          end
          OFS_RATE:     rate_nxt = sh;
          OFS_BYTERATE: brate_nxt = sh;
          OFS_ALIGN:    align_nxt = hi16;
          OFS_BITS: begin
            emit      = (hi16 != PCM_BITS);
            next_nxt  = FIRST_CHUNK_POS;
            next8_nxt = FIRST_CHUNK_POS + CHUNK_HDR_LEN;
            phase_nxt = PH_SKIP;
          end
          default: ;
        endcase
      end else if (ph == PH_ID && rel == REL_ID_END) begin
        phase_nxt = (sh == TAG_DATA) ? PH_DSIZE : PH_OSIZE;
      end else if (ph == PH_DSIZE && rel == REL_SIZE_END) begin
        emit    = 1'b1;
        emit_ok = 1'b1;
      end else if (ph == PH_OSIZE && rel == REL_SIZE_END) begin
        // skip this chunk, header included
        if (sh[31] || nh > MAX_NEXT_HDR) begin
          emit = 1'b1;
        end else begin
          next_nxt  = nh[31:0];
          next8_nxt = nh8;
          phase_nxt = PH_SKIP;
        end
      end
      // buffer ran out before a decision
      if (!emit && q_item.last_byte) begin
        emit = 1'b1;
      end
      if (emit) begin
        phase_nxt = PH_WAIT;
      end
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (pop && emit) begin
      out_valid_nxt       = 1'b1;
      out_nxt.status      = emit_ok ? STATUS_PASS : STATUS_FAIL;
      out_nxt.data_offset = emit_ok ? next8_r : '0;
      out_nxt.channels    = emit_ok ? chan_r : '0;
      out_nxt.sample_rate = emit_ok ? rate_r : '0;
      out_nxt.byte_rate   = emit_ok ? brate_r : '0;
      out_nxt.block_align = emit_ok ? align_r : '0;
    end else if (res_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      phase_r     <= PH_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // parser fields and result payload
  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    next_r  <= next_nxt;
    next8_r <= next8_nxt;
    chan_r  <= chan_nxt;
    rate_r  <= rate_nxt;
    brate_r <= brate_nxt;
    align_r <= align_nxt;
    out_r   <= out_nxt;
  end

`ifndef SYNTHESIS
  a_wait_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && emit) |=> (phase_r == PH_WAIT))
    else $error("parser did not return to wait after a result");

  a_pass_channels: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == STATUS_PASS) |-> (out_r.channels == 2'd1 ||
    out_r.channels == 2'd2))
    else $error("passing result with bad channel count");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == STATUS_FAIL) |-> (out_r.data_offset == '0 &&
    out_r.channels == '0))
    else $error("failing result carries nonzero fields");

  a_next8_track: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SKIP || phase_r == PH_ID || phase_r == PH_DSIZE ||
    phase_r == PH_OSIZE) |-> (next8_r == next_r + CHUNK_HDR_LEN))
    else $error("chunk end copy out of step with chunk position");
`endif

endmodule

### rtl/core/wav_header_parser_core.sv
// wav header parser top level: byte queue feeding the parser back end
// Takes a RIFF/WAVE file one byte per transaction (first_byte restarts the parse) and
// gives at most one result per file: pass with the data offset and fmt fields, or fail. It
// accepts one byte per clock when the result side is ready; the parser retires one byte
// per cycle from a QUEUE_DEPTH-entry input queue, and a result appears on the output once
// the byte that decides it has gone through the queue entry and then the result register. While
// a result waits on the output the parser takes no bytes, so the input stalls once the
// queue holds QUEUE_DEPTH bytes.
module wav_header_parser_core
  import wavhp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  wavhp_in_if.sink  in_ch,
  wavhp_out_if.source out_ch
);

  wavhp_item_t push_item;
  wavhp_item_t q_item;
  wavhp_res_t  res;
  logic        full, q_valid, pop;

  assign push_item.byte_value = in_ch.byte_value;
  assign push_item.first_byte = in_ch.first_byte;
  assign push_item.last_byte  = in_ch.last_byte;
  assign in_ch.ready          = !full;

  // front: accept and buffer bytes
  wavhp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_ch.valid),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  // back: parse bytes and hold the result transaction
  wavhp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .res_valid (out_ch.valid),
    .res_ready (out_ch.ready),
    .res       (res)
  );

  assign out_ch.status      = res.status;
  assign out_ch.data_offset = res.data_offset;
  assign out_ch.channels    = res.channels;
  assign out_ch.sample_rate = res.sample_rate;
  assign out_ch.byte_rate   = res.byte_rate;
  assign out_ch.block_align = res.block_align;

endmodule

### tb/sv/tb.sv
// self-checking testbench for the wav header parser: byte-stream stimulus, verdict prediction
`timescale 1ns / 100ps

module tb;
  import wavhp_pkg::*;

  // chunk tags that the parser skips
  localparam logic [31:0] TAG_LIST = 32'h5453_494C;
  localparam logic [31:0] TAG_FACT = 32'h7463_6166;
  localparam logic [31:0] TAG_JUNK = 32'h4B4E_554A;

  logic clk = 1'b0;
  logic rst_n;

  wavhp_in_if  in_ch ();
  wavhp_out_if out_ch ();

  wav_header_parser_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // parser state mirrored for prediction
  logic [31:0] rd_pos;
  logic [2:0]  rd_phase;
  logic [31:0] byte_window;
  logic [31:0] chunk_pos;
  logic [1:0]  fmt_channels;
  logic [31:0] fmt_rate;
  logic [31:0] fmt_byte_rate;
  logic [15:0] fmt_align;
  logic        file_done;

  wavhp_res_t pending_verdicts[$];
  wavhp_res_t oldest_verdict;
  logic [7:0] file_img[$];

  int  mismatch_count = 0;
  int  bytes_sent = 0;
  int  files_decided = 0;
  int  hold_request = 0;
  bit  src_idle_on = 1'b1;
  bit  sink_idle_on = 1'b1;

  function automatic void clear_parser();
    rd_pos        = '0;
    rd_phase      = PH_WAIT;
    byte_window   = '0;
    chunk_pos     = '0;
    fmt_channels  = '0;
    fmt_rate      = '0;
    fmt_byte_rate = '0;
    fmt_align     = '0;
    file_done     = 1'b0;
  endfunction

  // build the verdict for the current file and go back to waiting
  function automatic wavhp_res_t close_file(input logic ok, input logic [31:0] offset);
    wavhp_res_t r;
    r.status      = ok ? STATUS_PASS : STATUS_FAIL;
    r.data_offset = ok ? offset : '0;
    r.channels    = ok ? fmt_channels : '0;
    r.sample_rate = ok ? fmt_rate : '0;
    r.byte_rate   = ok ? fmt_byte_rate : '0;
    r.block_align = ok ? fmt_align : '0;
    file_done = 1'b1;
    rd_phase  = PH_WAIT;
    return r;
  endfunction

  // advance the mirrored parser by one byte; returns 1 when a verdict is due
  function automatic bit parse_byte(input logic [7:0] b, input logic first, input logic last,
                                    output wavhp_res_t verdict);
    logic [31:0] p;
    logic [31:0] rel;
    logic [15:0] hi16;
    logic [32:0] nh;
    bit reject;
    bit accept;
    reject = 1'b0;
    accept = 1'b0;
    if (first) begin
      clear_parser();
      rd_phase = PH_HEADER;
    end
    if (rd_phase == PH_WAIT)
      return 1'b0;

    p = rd_pos;
    rd_pos = p + 1;
    byte_window = {b, byte_window[31:8]};
    hi16 = byte_window[31:16];

    if (rd_phase == PH_HEADER) begin
      // fixed riff/wave/fmt layout
      case (p)
        OFS_RIFF:   reject = (byte_window != TAG_RIFF);
        OFS_WAVE:   reject = (byte_window != TAG_WAVE);
        OFS_FMT:    reject = (byte_window != TAG_FMT);
        OFS_FORMAT: reject = (hi16 != PCM_FORMAT);
        OFS_CHANNELS: begin
          if (hi16 != MONO && hi16 != STEREO) reject = 1'b1;
          else fmt_channels = hi16[1:0];
        end
        OFS_RATE:     fmt_rate = byte_window;
        OFS_BYTERATE: fmt_byte_rate = byte_window;
        OFS_ALIGN:    fmt_align = hi16;
        OFS_BITS: begin
          if (hi16 != PCM_BITS) begin
            reject = 1'b1;
          end else begin
            chunk_pos = FIRST_CHUNK_POS;
            rd_phase  = PH_SKIP;
          end
        end
        default: ;
      endcase
    end else begin
      // chunk walk: id, size, then skip to the next header
      if (rd_phase == PH_SKIP && p == chunk_pos) rd_phase = PH_ID;
      rel = p - chunk_pos;
      if (rd_phase == PH_ID && rel == REL_ID_END) begin
        rd_phase = (byte_window == TAG_DATA) ? PH_DSIZE : PH_OSIZE;
      end else if (rd_phase == PH_DSIZE && rel == REL_SIZE_END) begin
        accept = 1'b1;
      end else if (rd_phase == PH_OSIZE && rel == REL_SIZE_END) begin
        nh = {1'b0, chunk_pos} + {1'b0, CHUNK_HDR_LEN} + {1'b0, byte_window};
        if (byte_window[31] || nh > MAX_NEXT_HDR) begin
          reject = 1'b1;
        end else begin
          chunk_pos = nh[31:0];
          rd_phase  = PH_SKIP;
        end
      end
    end

    if (accept) begin
      verdict = close_file(1'b1, chunk_pos + CHUNK_HDR_LEN);
      return 1'b1;
    end
    if (reject || (last && !file_done)) begin
      verdict = close_file(1'b0, '0);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // one byte transaction, with an optional idle burst ahead of it
  task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
    wavhp_res_t verdict;
    bit due;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.byte_value <= b;
    in_ch.first_byte <= first;
    in_ch.last_byte  <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    due = parse_byte(b, first, last, verdict);
    if (due) begin
      pending_verdicts.push_back(verdict);
      files_decided++;
    end
    bytes_sent++;
  endtask

  // file image builders
  task automatic put16(input logic [15:0] v);
    file_img.push_back(v[7:0]);
    file_img.push_back(v[15:8]);
  endtask

  task automatic put32(input logic [31:0] v);
    put16(v[15:0]);
    put16(v[31:16]);
  endtask

  task automatic put_fmt_header(input logic [15:0] chans, input logic [31:0] rate,
                                input logic [31:0] brate, input logic [15:0] align);
    file_img.delete();
    put32(TAG_RIFF);
    put32($urandom);
    put32(TAG_WAVE);
    put32(TAG_FMT);
    put32(32'd16);
    put16(PCM_FORMAT);
    put16(chans);
    put32(rate);
    put32(brate);
    put16(align);
    put16(PCM_BITS);
  endtask

  task automatic put_chunk(input logic [31:0] tag, input logic [31:0] size, input int body_len);
    logic [7:0] fill;
    put32(tag);
    put32(size);
    repeat (body_len) begin
      fill = 8'($urandom);
      file_img.push_back(fill);
    end
  endtask

  task automatic send_image(input int count, input bit mark_last);
    if (count > file_img.size()) count = file_img.size();
    for (int i = 0; i < count; i++)
      send_byte(file_img[i], i == 0, mark_last && i == count - 1);
  endtask

  task automatic put_random_wav();
    logic [31:0] tag;
    int n;
    int len;
    put_fmt_header(16'($urandom_range(1, 2)), $urandom, $urandom, 16'($urandom));
    // fmt chunk size is never looked at
    if ($urandom_range(0, 3) == 0)
      for (int i = 16; i < 20; i++) file_img[i] = 8'($urandom);
    n = $urandom_range(0, 3);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: tag = TAG_LIST;
        1: tag = TAG_DATA ^ (32'h1 << $urandom_range(0, 31));
        2: tag = TAG_FACT;
        default: tag = $urandom;
      endcase
      len = $urandom_range(0, 24);
      put_chunk(tag, len, len);
    end
    put_chunk(TAG_DATA, $urandom, $urandom_range(0, 6));
  endtask

  task automatic send_header_variant(input int idx, input logic [7:0] value);
    put_fmt_header(STEREO, 32'd48000, 32'd192000, 16'd4);
    put_chunk(TAG_DATA, 32'd64, 2);
    file_img[idx] = value;
    send_image(file_img.size(), 1'b1);
  endtask

  // bytes with no file open are dropped
  task automatic test_ignored_bytes();
    send_byte(8'hA5, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b0);
  endtask

  task automatic test_good_files();
    // data right after fmt, decided on the last byte of the buffer
    put_fmt_header(MONO, 32'd0, 32'd0, 16'd0);
    put_chunk(TAG_DATA, 32'd0, 0);
    send_image(file_img.size(), 1'b1);
    // all-ones fmt fields, trailing bytes after the verdict are ignored
    put_fmt_header(STEREO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    put_chunk(TAG_LIST, 32'd4, 4);
    put_chunk(TAG_DATA, 32'hFFFF_FFFF, 6);
    send_image(file_img.size(), 1'b0);
    // empty and odd-sized chunks ahead of data
    put_fmt_header(STEREO, 32'd44100, 32'd176400, 16'd4);
    put_chunk(TAG_JUNK, 32'd0, 0);
    put_chunk(TAG_FACT, 32'd7, 7);
    put_chunk(TAG_DATA, 32'd1000, 3);
    send_image(file_img.size(), 1'b1);
    // tag one bit away from data must be skipped
    put_fmt_header(MONO, 32'd8000, 32'd16000, 16'd2);
    put_chunk(TAG_DATA ^ 32'h8000_0000, 32'd2, 2);
    put_chunk(TAG_DATA, 32'd16, 0);
    send_image(file_img.size(), 1'b1);
  endtask

  task automatic test_header_rejects();
    send_header_variant(0, 8'h72);
    send_header_variant(8, 8'h77);
    send_header_variant(12, 8'h46);
    send_header_variant(OFS_FORMAT - 1, 8'h00);
    send_header_variant(OFS_FORMAT - 1, 8'h03);
    send_header_variant(OFS_FORMAT, 8'h01);
    send_header_variant(OFS_CHANNELS - 1, 8'h00);
    send_header_variant(OFS_CHANNELS - 1, 8'h03);
    send_header_variant(OFS_CHANNELS, 8'h80);
    send_header_variant(OFS_BITS - 1, 8'd8);
    send_header_variant(OFS_BITS - 1, 8'd24);
    send_header_variant(OFS_BITS, 8'hFF);
  endtask

  task automatic test_chunk_failures();
    // negative chunk sizes
    put_fmt_header(MONO, 32'd22050, 32'd44100, 16'd2);
    put_chunk(TAG_LIST, 32'h8000_0000, 0);
    put_chunk(TAG_DATA, 32'd0, 0);
    send_image(file_img.size(), 1'b1);
    put_fmt_header(STEREO, 32'd22050, 32'd88200, 16'd4);
    put_chunk(TAG_FACT, 32'hFFFF_FFFF, 0);
    send_image(file_img.size(), 1'b0);
    // buffer of a single byte
    send_byte(8'h52, 1'b1, 1'b1);
    // buffer ends in the fmt fields, in the data header, in a skipped body
    put_fmt_header(MONO, 32'd11025, 32'd22050, 16'd2);
    put_chunk(TAG_DATA, 32'd4, 0);
    send_image(20, 1'b1);
    send_image(40, 1'b1);
    put_fmt_header(STEREO, 32'd96000, 32'd384000, 16'd4);
    put_chunk(TAG_LIST, 32'd20, 20);
    put_chunk(TAG_DATA, 32'd4, 0);
    send_image(54, 1'b1);
  endtask

  task automatic test_restarts();
    // abandoned in the fmt fields
    put_fmt_header(STEREO, 32'd32000, 32'd128000, 16'd4);
    put_chunk(TAG_DATA, 32'd8, 0);
    send_image(30, 1'b0);
    send_image(file_img.size(), 1'b1);
    // abandoned in the data header, then a lone first byte
    send_image(41, 1'b0);
    send_byte(8'h52, 1'b1, 1'b0);
    put_fmt_header(MONO, 32'd16000, 32'd32000, 16'd2);
    put_chunk(TAG_DATA, 32'd8, 1);
    send_image(file_img.size(), 1'b1);
  endtask

  // result side held off while short failing files keep coming
  task automatic test_backpressure();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    hold_request = 300;
    repeat (40) begin
      file_img.delete();
      put32($urandom | 32'h8000_0000);
      send_image(4, 1'b0);
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  task automatic random_file();
    int kind;
    int n;
    put_random_wav();
    kind = $urandom_range(0, 99);
    if (kind < 65) begin
      send_image(file_img.size(), 1'($urandom_range(0, 1)));
    end else if (kind < 75) begin
      // single bit upset in the fixed header
      n = $urandom_range(0, 35);
      file_img[n] = file_img[n] ^ (8'h01 << $urandom_range(0, 7));
      send_image(file_img.size(), 1'b1);
    end else if (kind < 83) begin
      send_image($urandom_range(1, file_img.size()), 1'b1);
    end else if (kind < 90) begin
      // left open, the next file restarts the parser
      send_image($urandom_range(1, file_img.size() - 1), 1'b0);
    end else if (kind < 95) begin
      put_fmt_header(16'($urandom_range(1, 2)), $urandom, $urandom, 16'($urandom));
      put_chunk($urandom_range(0, 1) ? TAG_LIST : TAG_JUNK, {1'b1, 31'($urandom)}, 0);
      put_chunk(TAG_DATA, 32'd0, 0);
      send_image(file_img.size(), 1'b1);
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) send_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_random_files(input int byte_budget, input int verdict_goal,
                                   input bit with_idles);
    int b0;
    int d0;
    b0 = bytes_sent;
    d0 = files_decided;
    while (bytes_sent - b0 < byte_budget || files_decided - d0 < verdict_goal) begin
      src_idle_on  = with_idles && $urandom_range(0, 3) != 0;
      sink_idle_on = with_idles && $urandom_range(0, 3) != 0;
      random_file();
    end
  endtask

  // result sink: random stalls, plus a long hold on request
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic flag_field(input string field, input logic [31:0] want, input logic [31:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    mismatch_count++;
  endtask

  // compare each result transaction with the oldest predicted verdict
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0b offset %0h",
                 $time, out_ch.status, out_ch.data_offset);
        mismatch_count++;
      end else begin
        oldest_verdict = pending_verdicts.pop_front();
        if (out_ch.status !== oldest_verdict.status)
          flag_field("status", 32'(oldest_verdict.status), 32'(out_ch.status));
        if (out_ch.data_offset !== oldest_verdict.data_offset)
          flag_field("data_offset", oldest_verdict.data_offset, out_ch.data_offset);
        if (out_ch.channels !== oldest_verdict.channels)
          flag_field("channels", 32'(oldest_verdict.channels), 32'(out_ch.channels));
        if (out_ch.sample_rate !== oldest_verdict.sample_rate)
          flag_field("sample_rate", oldest_verdict.sample_rate, out_ch.sample_rate);
        if (out_ch.byte_rate !== oldest_verdict.byte_rate)
          flag_field("byte_rate", oldest_verdict.byte_rate, out_ch.byte_rate);
        if (out_ch.block_align !== oldest_verdict.block_align)
          flag_field("block_align", 32'(oldest_verdict.block_align),
                     32'(out_ch.block_align));
      end
    end
  end

  // main sequence
  initial begin
    clear_parser();
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.byte_value <= '0;
    in_ch.first_byte <= 1'b0;
    in_ch.last_byte  <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_ignored_bytes();
    test_good_files();
    test_header_rejects();
    test_chunk_failures();
    test_restarts();
    test_backpressure();
    test_random_files(550, 8, 1'b1);
    test_random_files(150, 2, 1'b0);
    in_ch.valid <= 1'b0;

    // drain the predicted verdicts, then let the result path settle
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // run limit
  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### wav_header_parser_core.f
rtl/core/wavhp_pkg.sv
rtl/core/wavhp_if.sv
rtl/core/wavhp_queue.sv
rtl/core/wavhp_parse.sv
rtl/core/wav_header_parser_core.sv
tb/sv/tb.sv
